// ----- hdl/btff_pkg.sv -----
// shared types, constants and tag helpers for the boundary tag allocator
package btff_pkg;

    localparam int HEAP_WORDS = 4096;
    localparam int AW         = $clog2(HEAP_WORDS);
    localparam int TAG_W      = 16;
    localparam int WSIZE      = 8;
    localparam int MIN_SPLIT  = 4 * WSIZE;
    localparam int FIRST_SIZE = (HEAP_WORDS - 4) * WSIZE;

    localparam logic [1:0] STATUS_DONE    = 2'd0;
    localparam logic [1:0] STATUS_IGNORED = 2'd1;
    localparam logic [1:0] STATUS_NO_FIT  = 2'd2;

    typedef struct packed {
        logic        func;
        logic [15:0] req_bytes;
        logic [14:0] payload_addr;
    } in_beat_t;

    typedef struct packed {
        logic [14:0] result_addr;
        logic [1:0]  status;
    } out_beat_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_A_CHK,
        ST_A_REM_HDR,
        ST_A_REM_FTR,
        ST_A_HDR,
        ST_A_FTR,
        ST_F_HDR_CHK,
        ST_F_FTR_CHK,
        ST_F_PREV,
        ST_F_NEXT,
        ST_F_WR_HDR,
        ST_F_WR_FTR,
        ST_RESP
    } state_t;

    typedef enum logic [2:0] {
        RD_P,
        RD_NX_CUR,
        RD_NXM1_CUR,
        RD_PREV,
        RD_NX_REG
    } rd_sel_t;

    typedef enum logic [2:0] {
        WR_CLR,
        WR_REM_HDR,
        WR_REM_FTR,
        WR_A_HDR,
        WR_A_FTR,
        WR_F_HDR,
        WR_F_FTR
    } wr_sel_t;

    typedef struct packed {
        logic       load_req;
        logic       rd_en;
        rd_sel_t    rd_sel;
        logic       wr_en;
        wr_sel_t    wr_sel;
        logic       clr_inc;
        logic       walk_step;
        logic       cap_tag;
        logic       cap_prev;
        logic       cap_next;
        logic       set_res;
        logic [1:0] res_status;
        logic       res_grant;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic is_free;
        logic ign_req;
        logic clr_last;
        logic a_stop;
        logic a_fit;
        logic a_split;
        logic f_hdr_bad;
        logic f_ftr_bad;
    } sts_t;

    // tag content that the clearing pass writes to a heap word after reset
    function automatic logic [TAG_W-1:0] init_tag(input logic [AW-1:0] w);
        logic [TAG_W-1:0] v;
        v = '0;
        if (w == AW'(0))
            v = TAG_W'(WSIZE + 1);
        else if (w == AW'(1) || w == AW'(2))
            v = TAG_W'(2 * WSIZE + 1);
        else if (w == AW'(3) || w == AW'(HEAP_WORDS - 2))
            v = TAG_W'(FIRST_SIZE);
        else if (w == AW'(HEAP_WORDS - 1))
            v = TAG_W'(1);
        return v;
    endfunction

endpackage

// ----- hdl/boundary_tag_first_fit_allocator_unit.sv -----
// top level of the boundary tag first-fit heap allocator
// Manages a 4096-word heap of 8-byte words whose blocks carry size/allocated
// header and footer tags in a single-port-read tag RAM. After reset a clearing
// pass writes all 4096 words of the initial heap image, one word per cycle;
// no request is taken until it ends. A request is taken only when the unit is
// idle and each produces exactly one result beat. An allocate reads one tag
// per block visited by the first-fit walk and, when a block is granted, writes
// two tags, or four when the block is split; a free reads four tags to check
// and merge and writes two. A zero size allocate, a null free or a free below
// the first block answers with status 1, as does a free whose header check
// fails or whose footer does not match. A result beat held by a stall does not
// keep the unit busy, but the next result is not loaded until the held beat is taken.
module boundary_tag_first_fit_allocator_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  btff_pkg::in_beat_t  in_beat,
    output logic                out_valid,
    input  logic                out_stall,
    output btff_pkg::out_beat_t out_beat
);

    btff_pkg::cmd_t cmd;
    btff_pkg::sts_t sts;

    btff_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    btff_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_beat  (in_beat),
        .cmd      (cmd),
        .sts      (sts),
        .out_beat (out_beat)
    );

endmodule

// ----- hdl/btff_ram.sv -----
// generic single write, single read RAM with registered read data
module btff_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- hdl/btff_datapath.sv -----
// tag store, address arithmetic and result registers of the allocator
module btff_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  btff_pkg::in_beat_t in_beat,
    input  btff_pkg::cmd_t     cmd,
    output btff_pkg::sts_t     sts,
    output btff_pkg::out_beat_t out_beat
);

    localparam int AW = btff_pkg::AW;
    localparam int TW = btff_pkg::TAG_W;

    logic                 func_reg;
    logic                 ign_reg;
    logic [16:0]          need_reg;
    logic [AW-1:0]        p_reg;
    logic [TW-1:0]        t_reg;
    logic [AW-1:0]        nx_reg;
    logic [AW-1:0]        start_reg;
    logic [TW-1:0]        total_reg;
    logic [AW-1:0]        clr_reg;
    logic [1:0]           res_status_reg;
    logic [14:0]          res_addr_reg;
    btff_pkg::out_beat_t  out_reg;

    logic [16:0]          need_next;
    logic [AW-1:0]        b_raw;
    logic                 ign_next;
    logic [AW-1:0]        p_next;

    logic [TW-1:0]        rd_data;
    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        wr_addr;
    logic [TW-1:0]        wr_data;

    logic [12:0]          sw_cur;
    logic [TW-1:0]        s_cur;
    logic [13:0]          nx_cur;
    logic [12:0]          sw_reg;
    logic [12:0]          nw_reg;
    logic [TW-1:0]        rem_reg;
    logic                 split_reg;
    logic                 merge_p;
    logic                 merge_n;

    // request decode
    always_comb
    begin
        b_raw = in_beat.payload_addr[14:3];
        if (in_beat.req_bytes <= 16'(btff_pkg::WSIZE))
            need_next = 17'(3 * btff_pkg::WSIZE);
        else
            need_next = ({1'b0, in_beat.req_bytes} + 17'(2 * btff_pkg::WSIZE + 7))
                        & ~17'd7;
        if (in_beat.func)
        begin
            ign_next = (in_beat.payload_addr == 15'd0) || (b_raw < AW'(4));
            p_next   = b_raw - AW'(1);
        end
        else
        begin
            ign_next = (in_beat.req_bytes == 16'd0);
            p_next   = AW'(1);
        end
    end

    // current tag from the store
    assign sw_cur = rd_data[15:3];
    assign s_cur  = {rd_data[15:3], 3'b000};
    assign nx_cur = 14'(p_reg) + 14'(sw_cur);

    assign sw_reg    = t_reg[15:3];
    assign nw_reg    = need_reg[15:3];
    assign rem_reg   = {t_reg[15:3], 3'b000} - need_reg[15:0];
    assign split_reg = rem_reg >= TW'(btff_pkg::MIN_SPLIT);

    assign merge_p = !rd_data[0] && (sw_cur != 13'd0)
                     && (14'(sw_cur) <= 14'(p_reg) - 14'd3);
    assign merge_n = !rd_data[0] && (sw_cur != 13'd0)
                     && (14'(nx_reg) + 14'(sw_cur) < 14'(btff_pkg::HEAP_WORDS));

    always_comb
    begin
        sts.is_free   = func_reg;
        sts.ign_req   = ign_reg;
        sts.clr_last  = (clr_reg == AW'(btff_pkg::HEAP_WORDS - 1));
        sts.a_stop    = (sw_cur == 13'd0) || (nx_cur >= 14'(btff_pkg::HEAP_WORDS));
        sts.a_fit     = !rd_data[0] && ({1'b0, s_cur} >= need_reg);
        sts.a_split   = (s_cur - need_reg[15:0]) >= TW'(btff_pkg::MIN_SPLIT);
        sts.f_hdr_bad = !rd_data[0] || (sw_cur == 13'd0)
                        || (nx_cur >= 14'(btff_pkg::HEAP_WORDS));
        sts.f_ftr_bad = (rd_data != t_reg);
    end

    always_comb
    begin
        case (cmd.rd_sel)
            btff_pkg::RD_P:        rd_addr = p_reg;
            btff_pkg::RD_NX_CUR:   rd_addr = nx_cur[AW-1:0];
            btff_pkg::RD_NXM1_CUR: rd_addr = AW'(nx_cur - 14'd1);
            btff_pkg::RD_PREV:     rd_addr = p_reg - AW'(1);
            btff_pkg::RD_NX_REG:   rd_addr = nx_reg;
            default:               rd_addr = p_reg;
        endcase
    end

    always_comb
    begin
        case (cmd.wr_sel)
            btff_pkg::WR_CLR:
            begin
                wr_addr = clr_reg;
                wr_data = btff_pkg::init_tag(clr_reg);
            end
            btff_pkg::WR_REM_HDR:
            begin
                wr_addr = AW'(14'(p_reg) + 14'(nw_reg));
                wr_data = rem_reg;
            end
            btff_pkg::WR_REM_FTR:
            begin
                wr_addr = AW'(14'(p_reg) + 14'(sw_reg) - 14'd1);
                wr_data = rem_reg;
            end
            btff_pkg::WR_A_HDR:
            begin
                wr_addr = p_reg;
                wr_data = split_reg ? (need_reg[15:0] | TW'(1))
                                    : ({t_reg[15:3], 3'b000} | TW'(1));
            end
            btff_pkg::WR_A_FTR:
            begin
                wr_addr = split_reg ? AW'(14'(p_reg) + 14'(nw_reg) - 14'd1)
                                    : AW'(14'(p_reg) + 14'(sw_reg) - 14'd1);
                wr_data = split_reg ? (need_reg[15:0] | TW'(1))
                                    : ({t_reg[15:3], 3'b000} | TW'(1));
            end
            btff_pkg::WR_F_HDR:
            begin
                wr_addr = start_reg;
                wr_data = total_reg;
            end
            btff_pkg::WR_F_FTR:
            begin
                wr_addr = AW'(14'(start_reg) + 14'(total_reg[15:3]) - 14'd1);
                wr_data = total_reg;
            end
            default:
            begin
                wr_addr = clr_reg;
                wr_data = '0;
            end
        endcase
    end

    btff_ram #(
        .WIDTH (TW),
        .DEPTH (btff_pkg::HEAP_WORDS)
    ) u_tag_ram (
        .clk     (clk),
        .wr_en   (cmd.wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (cmd.clr_inc)
        begin
            clr_reg <= clr_reg + AW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            func_reg <= in_beat.func;
            ign_reg  <= ign_next;
            need_reg <= need_next;
            p_reg    <= p_next;
        end
        if (cmd.walk_step)
        begin
            p_reg <= nx_cur[AW-1:0];
        end
        if (cmd.cap_tag)
        begin
            t_reg  <= rd_data;
            nx_reg <= nx_cur[AW-1:0];
        end
        if (cmd.cap_prev)
        begin
            start_reg <= merge_p ? (p_reg - AW'(sw_cur)) : p_reg;
            total_reg <= {t_reg[15:3], 3'b000} + (merge_p ? s_cur : TW'(0));
        end
        if (cmd.cap_next)
        begin
            total_reg <= total_reg + (merge_n ? s_cur : TW'(0));
        end
        if (cmd.set_res)
        begin
            res_status_reg <= cmd.res_status;
            res_addr_reg   <= cmd.res_grant ? 15'({p_reg + AW'(1), 3'b000}) : 15'd0;
        end
        if (cmd.out_load)
        begin
            out_reg.result_addr <= res_addr_reg;
            out_reg.status      <= res_status_reg;
        end
    end

    assign out_beat = out_reg;

    // a walk step always moves forward through the heap
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk_step |=> p_reg > $past(p_reg))
        else $error("walk did not advance");

    // only a free block is ever granted
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr_en && cmd.wr_sel == btff_pkg::WR_A_HDR) |-> !t_reg[0])
        else $error("granted block was not free");

    // a merged block is written back as free
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr_en && cmd.wr_sel == btff_pkg::WR_F_HDR) |-> !total_reg[0])
        else $error("freed block written as allocated");

endmodule

// ----- hdl/btff_ctrl.sv -----
// state machine sequencing allocate, free and the clearing pass
module btff_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  logic            out_stall,
    input  btff_pkg::sts_t  sts,
    output btff_pkg::cmd_t  cmd
);

    btff_pkg::state_t state_reg;
    btff_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            btff_pkg::ST_CLEAR:
                if (sts.clr_last)
                    state_next = btff_pkg::ST_IDLE;
            btff_pkg::ST_IDLE:
                if (in_valid)
                    state_next = btff_pkg::ST_DISPATCH;
            btff_pkg::ST_DISPATCH:
                if (sts.ign_req)
                    state_next = btff_pkg::ST_RESP;
                else if (sts.is_free)
                    state_next = btff_pkg::ST_F_HDR_CHK;
                else
                    state_next = btff_pkg::ST_A_CHK;
            btff_pkg::ST_A_CHK:
                if (sts.a_stop)
                    state_next = btff_pkg::ST_RESP;
                else if (sts.a_fit)
                    state_next = sts.a_split ? btff_pkg::ST_A_REM_HDR : btff_pkg::ST_A_HDR;
            btff_pkg::ST_A_REM_HDR: state_next = btff_pkg::ST_A_REM_FTR;
            btff_pkg::ST_A_REM_FTR: state_next = btff_pkg::ST_A_HDR;
            btff_pkg::ST_A_HDR:     state_next = btff_pkg::ST_A_FTR;
            btff_pkg::ST_A_FTR:     state_next = btff_pkg::ST_RESP;
            btff_pkg::ST_F_HDR_CHK:
                state_next = sts.f_hdr_bad ? btff_pkg::ST_RESP : btff_pkg::ST_F_FTR_CHK;
            btff_pkg::ST_F_FTR_CHK:
                state_next = sts.f_ftr_bad ? btff_pkg::ST_RESP : btff_pkg::ST_F_PREV;
            btff_pkg::ST_F_PREV:    state_next = btff_pkg::ST_F_NEXT;
            btff_pkg::ST_F_NEXT:    state_next = btff_pkg::ST_F_WR_HDR;
            btff_pkg::ST_F_WR_HDR:  state_next = btff_pkg::ST_F_WR_FTR;
            btff_pkg::ST_F_WR_FTR:  state_next = btff_pkg::ST_RESP;
            btff_pkg::ST_RESP:
                if (out_free)
                    state_next = btff_pkg::ST_IDLE;
            default:                state_next = btff_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.rd_sel     = btff_pkg::RD_P;
        cmd.wr_sel     = btff_pkg::WR_CLR;
        cmd.res_status = btff_pkg::STATUS_DONE;
        case (state_reg)
            btff_pkg::ST_CLEAR:
            begin
                cmd.wr_en   = 1'b1;
                cmd.clr_inc = 1'b1;
            end
            btff_pkg::ST_IDLE:
                cmd.load_req = in_valid;
            btff_pkg::ST_DISPATCH:
                if (sts.ign_req)
                begin
                    cmd.set_res    = 1'b1;
                    cmd.res_status = btff_pkg::STATUS_IGNORED;
                end
                else
                begin
                    cmd.rd_en = 1'b1;
                end
            btff_pkg::ST_A_CHK:
            begin
                cmd.cap_tag = 1'b1;
                if (sts.a_stop)
                begin
                    cmd.set_res    = 1'b1;
                    cmd.res_status = btff_pkg::STATUS_NO_FIT;
                end
                else if (!sts.a_fit)
                begin
                    cmd.walk_step = 1'b1;
                    cmd.rd_en     = 1'b1;
                    cmd.rd_sel    = btff_pkg::RD_NX_CUR;
                end
            end
            btff_pkg::ST_A_REM_HDR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = btff_pkg::WR_REM_HDR;
            end
            btff_pkg::ST_A_REM_FTR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = btff_pkg::WR_REM_FTR;
            end
            btff_pkg::ST_A_HDR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = btff_pkg::WR_A_HDR;
            end
            btff_pkg::ST_A_FTR:
            begin
                cmd.wr_en     = 1'b1;
                cmd.wr_sel    = btff_pkg::WR_A_FTR;
                cmd.set_res   = 1'b1;
                cmd.res_grant = 1'b1;
            end
            btff_pkg::ST_F_HDR_CHK:
            begin
                cmd.cap_tag = 1'b1;
                if (sts.f_hdr_bad)
                begin
                    cmd.set_res    = 1'b1;
                    cmd.res_status = btff_pkg::STATUS_IGNORED;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = btff_pkg::RD_NXM1_CUR;
                end
            end
            btff_pkg::ST_F_FTR_CHK:
                if (sts.f_ftr_bad)
                begin
                    cmd.set_res    = 1'b1;
                    cmd.res_status = btff_pkg::STATUS_IGNORED;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = btff_pkg::RD_PREV;
                end
            btff_pkg::ST_F_PREV:
            begin
                cmd.cap_prev = 1'b1;
                cmd.rd_en    = 1'b1;
                cmd.rd_sel   = btff_pkg::RD_NX_REG;
            end
            btff_pkg::ST_F_NEXT:
                cmd.cap_next = 1'b1;
            btff_pkg::ST_F_WR_HDR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = btff_pkg::WR_F_HDR;
            end
            btff_pkg::ST_F_WR_FTR:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = btff_pkg::WR_F_FTR;
                cmd.set_res = 1'b1;
            end
            btff_pkg::ST_RESP:
                cmd.out_load = out_free;
            default:
                cmd.load_req = 1'b0;
        endcase
    end

    // result stays up until the beat is taken
    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= btff_pkg::ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != btff_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_en |-> (state_reg != btff_pkg::ST_IDLE && state_reg != btff_pkg::ST_RESP))
        else $error("tag write outside a write state");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> (out_valid && state_reg == btff_pkg::ST_IDLE))
        else $error("result load did not finish the request");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_req && state_reg == btff_pkg::ST_IDLE) |=> in_stall)
        else $error("accepted a second request while busy");

endmodule
